>>> src/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg: shared definitions for the refcounted slot allocator
// Command and status codes, the controller-to-datapath struct and the
// count display helper.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int DEF_MAX_SLOTS  = 1024;
  localparam int DEF_COUNT_BITS = 16;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int SHOW_W   = 16;
  localparam int PEND_W   = 16;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_REF = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic capture;  // beat accepted: latch command, launch memory reads
    logic exec;     // read data valid: update state, register result
  } rsa_ctrl_t;

  // Counts wider than the result field are shown saturated.
  function automatic logic [SHOW_W-1:0] shown_count(input logic [31:0] c);
    logic [SHOW_W-1:0] r;
    r = (c > 32'h0000_FFFF) ? 16'hFFFF : c[SHOW_W-1:0];
    return r;
  endfunction

endpackage

>>> src/refcounted_slot_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_slot_allocator: slot allocator with per-slot reference counts
// Hands out slots from a free stack or a high-water mark, tracks counts.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive command_i and slot_id_i with start_i high; the
//   beat is taken at a rising edge where start_i is high and busy_o is low.
//   Result channel: done_o is high for exactly one cycle with the result
//   beat on granted_id_o, status_o, freed_o, ref_count_o, change_count_o.
//   The receiver cannot stall; it must sample the result in that cycle.
//   The accept edge registers the beat and its memory reads, and the end
//   of the execute state registers the result. The entry memory and the
//   free stack have registered reads, so each command has a read step and
//   a read-modify-write step; busy_o covers the second, blocking new beats.
//   The result register frees the block, so a new command can be taken in
//   the same cycle that the previous result is shown.
//   Reset: asynchronous, active low. Free stack pointer, high-water mark and
//   pending-change counter go to zero. Slot entries need no clearing pass:
//   slots at or above the high-water mark read as dead with count zero, so
//   the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator import rsa_pkg::*; #(
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [SLOT_W-1:0]   slot_id_i,
  output logic                done_o,
  output logic [SLOT_W-1:0]   granted_id_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                freed_o,
  output logic [SHOW_W-1:0]   ref_count_o,
  output logic [PEND_W-1:0]   change_count_o
);

  rsa_ctrl_t ctrl;

  // Sequencer: accept, then execute
  rsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  // Tables, stack, counters and result registers
  rsa_datapath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .command_i      (command_i),
    .slot_id_i      (slot_id_i),
    .done_o         (done_o),
    .granted_id_o   (granted_id_o),
    .status_o       (status_o),
    .freed_o        (freed_o),
    .ref_count_o    (ref_count_o),
    .change_count_o (change_count_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted beat always moves the block into its execute cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not enter execute");

  // Execute always yields exactly one result and returns the block to idle.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o && !busy_o)
    else $error("execute did not produce a result");

  // A result only follows an execute cycle.
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without execute");

  // A full allocate grants nothing and frees nothing.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> granted_id_o == '0 && ref_count_o == '0 && !freed_o)
    else $error("full status with payload");
`endif

endmodule

>>> src/rsa_ctrl.sv
// ----------------------------------------------------------------------------
// rsa_ctrl: command sequencer
// Two-state controller: accept a beat, then execute it in the next cycle.
// ----------------------------------------------------------------------------
module rsa_ctrl import rsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output rsa_ctrl_t ctrl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = start_i ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q == ST_EXEC);
  assign ctrl_o.capture = start_i && (state_q == ST_IDLE);
  assign ctrl_o.exec    = (state_q == ST_EXEC);

endmodule

>>> src/rsa_datapath.sv
// ----------------------------------------------------------------------------
// rsa_datapath: slot tables, free stack and result registers
// Entry memory holds {live, count} per slot; entries at or above the
// high-water mark were never written and read as dead with count zero.
// ----------------------------------------------------------------------------
module rsa_datapath import rsa_pkg::*; #(
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsa_ctrl_t           ctrl_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [SLOT_W-1:0]   slot_id_i,
  output logic                done_o,
  output logic [SLOT_W-1:0]   granted_id_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                freed_o,
  output logic [SHOW_W-1:0]   ref_count_o,
  output logic [PEND_W-1:0]   change_count_o
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int PTR_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = ((PTR_W > SLOT_W) ? PTR_W : SLOT_W) + 1;
  localparam int ENT_W = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PTR_W-1:0]      PTR_MAX = PTR_W'(MAX_SLOTS);

  logic [ENT_W-1:0] entry_mem [MAX_SLOTS];
  logic [IDX_W-1:0] stack_mem [MAX_SLOTS];

  logic [CMD_W-1:0]  cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic              in_range_q, below_hw_q;
  logic [ENT_W-1:0]  entry_rd_q;
  logic [IDX_W-1:0]  stack_rd_q;
  logic [PTR_W-1:0]  free_top_q, free_top_d;
  logic [PTR_W-1:0]  high_water_q, high_water_d;
  logic [PEND_W-1:0] pending_q, pending_d;

  logic              entry_we, stack_we;
  logic [IDX_W-1:0]  entry_wa, alloc_id;
  logic [ENT_W-1:0]  entry_wd;
  logic              live;
  logic [COUNT_BITS-1:0] cnt, cnt_new;
  logic [PEND_W-1:0] pend_inc;
  logic [SLOT_W-1:0] granted_d;
  logic [STATUS_W-1:0] status_d;
  logic              freed_d;
  logic [SHOW_W-1:0] count_d;

  // Beat capture and registered memory reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q      <= command_i;
      slot_q     <= slot_id_i;
      in_range_q <= CMP_W'(slot_id_i) < CMP_W'(MAX_SLOTS);
      below_hw_q <= CMP_W'(slot_id_i) < CMP_W'(high_water_q);
      entry_rd_q <= entry_mem[IDX_W'(slot_id_i)];
      stack_rd_q <= stack_mem[IDX_W'(free_top_q - 1'b1)];
    end
    if (entry_we) begin
      entry_mem[entry_wa] <= entry_wd;
    end
    if (stack_we) begin
      stack_mem[IDX_W'(free_top_q)] <= IDX_W'(slot_q);
    end
  end

  assign live     = below_hw_q && entry_rd_q[COUNT_BITS];
  assign cnt      = live ? entry_rd_q[COUNT_BITS-1:0] : '0;
  assign pend_inc = (pending_q != 16'hFFFF) ? pending_q + 1'b1 : pending_q;

  always_comb begin
    entry_we     = 1'b0;
    stack_we     = 1'b0;
    entry_wa     = IDX_W'(slot_q);
    entry_wd     = '0;
    alloc_id     = stack_rd_q;
    cnt_new      = cnt;
    free_top_d   = free_top_q;
    high_water_d = high_water_q;
    pending_d    = pending_q;
    granted_d    = '0;
    status_d     = ST_OK;
    freed_d      = 1'b0;
    count_d      = '0;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (free_top_q != '0) begin
          alloc_id   = stack_rd_q;
          free_top_d = free_top_q - 1'b1;
        end else if (high_water_q < PTR_MAX) begin
          alloc_id     = IDX_W'(high_water_q);
          high_water_d = high_water_q + 1'b1;
        end else begin
          status_d = ST_FULL;
        end
        if (status_d == ST_OK) begin
          entry_we  = 1'b1;
          entry_wa  = alloc_id;
          entry_wd  = {1'b1, {COUNT_BITS{1'b0}}};
          pending_d = pend_inc;
          granted_d = SLOT_W'(alloc_id);
        end
      end
      CMD_ADD_REF: begin
        if (!in_range_q || !live) begin
          status_d = ST_BAD;
        end else begin
          cnt_new  = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
          entry_we = 1'b1;
          entry_wd = {1'b1, cnt_new};
          count_d  = shown_count(32'(cnt_new));
        end
      end
      CMD_RELEASE: begin
        if (!in_range_q || !live || cnt == '0) begin
          status_d = ST_BAD;
          count_d  = in_range_q ? shown_count(32'(cnt)) : '0;
        end else begin
          cnt_new  = cnt - 1'b1;
          entry_we = 1'b1;
          entry_wd = {(cnt_new != '0), cnt_new};
          count_d  = shown_count(32'(cnt_new));
          if (cnt_new == '0) begin
            freed_d   = 1'b1;
            pending_d = pend_inc;
            if (free_top_q < PTR_MAX) begin
              stack_we   = 1'b1;
              free_top_d = free_top_q + 1'b1;
            end
          end
        end
      end
      CMD_MARK: begin
        if (!in_range_q) begin
          status_d = ST_BAD;
        end else begin
          pending_d = pend_inc;
          count_d   = shown_count(32'(cnt));
        end
      end
      CMD_CLEAR: pending_d = '0;
      default: ;
    endcase
    entry_we = entry_we && ctrl_i.exec;
    stack_we = stack_we && ctrl_i.exec;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q   <= '0;
      high_water_q <= '0;
      pending_q    <= '0;
      done_o       <= 1'b0;
    end else begin
      done_o <= ctrl_i.exec;
      if (ctrl_i.exec) begin
        free_top_q   <= free_top_d;
        high_water_q <= high_water_d;
        pending_q    <= pending_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      granted_id_o   <= granted_d;
      status_o       <= status_d;
      freed_o        <= freed_d;
      ref_count_o    <= count_d;
      change_count_o <= pending_d;
    end
  end

endmodule

>>> dv/refcounted_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_tb: self-checking bench for the slot allocator
// Drives allocate, add-ref, release, mark-changed and clear-changes commands
// in bursts with random gaps. A local model of the slot table, free stack,
// high-water mark and pending-change counter predicts every result beat,
// and a monitor compares each done_o beat against the oldest prediction.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator_tb import rsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS  = DEF_MAX_SLOTS;
  localparam int CNT_W      = DEF_COUNT_BITS;
  localparam int RAND_ITEMS = 600;
  localparam int RUN_BEATS  = 40;
  localparam int MAX_GAP    = 12;
  // Worst legal quiet stretch is a sender gap plus the result latency.
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 4;

  // Command codes the block ignores.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic                freed;
    logic [SHOW_W-1:0]   count;
    logic [PEND_W-1:0]   changes;
  } slot_result_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                start_i   = 1'b0;
  logic [CMD_W-1:0]    command_i = CMD_CLEAR;
  logic [SLOT_W-1:0]   slot_id_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [SLOT_W-1:0]   granted_id_o;
  logic [STATUS_W-1:0] status_o;
  logic                freed_o;
  logic [SHOW_W-1:0]   ref_count_o;
  logic [PEND_W-1:0]   change_count_o;

  refcounted_slot_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .slot_id_i     (slot_id_i),
    .done_o        (done_o),
    .granted_id_o  (granted_id_o),
    .status_o      (status_o),
    .freed_o       (freed_o),
    .ref_count_o   (ref_count_o),
    .change_count_o(change_count_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Allocator model state
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  slot_count [NUM_SLOTS];
  bit                slot_live  [NUM_SLOTS];
  logic [SLOT_W-1:0] free_ids   [NUM_SLOTS];  // only entries below free_depth are read
  int unsigned       free_depth;
  int unsigned       fresh_mark;              // slots ever handed out fresh
  logic [PEND_W-1:0] pending;
  int unsigned       live_ids[$];             // live slots, for picking targets

  slot_result_t expected_q[$];

  int n_sent, n_checked, n_mismatch, n_grant, n_free, n_full, n_bad;
  int burst_left;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_count[i] = '0;
      slot_live[i]  = 1'b0;
    end
    free_depth = 0;
    fresh_mark = 0;
    pending    = '0;
  end

  function automatic logic [SHOW_W-1:0] clip_count(input logic [CNT_W-1:0] c);
    if (CNT_W > SHOW_W && c > {SHOW_W{1'b1}})
      return '1;
    return SHOW_W'(c);
  endfunction

  function automatic void bump_changes();
    if (pending != '1)
      pending = pending + 1'b1;
  endfunction

  // Updates the model for one accepted command and returns its result beat.
  function automatic slot_result_t apply_command(input logic [CMD_W-1:0]  cmd,
                                                 input logic [SLOT_W-1:0] slot);
    slot_result_t r;
    int unsigned  id;
    int           hits[$];
    bit           in_range;
    r        = '0;
    in_range = (int'(slot) < NUM_SLOTS);
    case (cmd)
      CMD_ALLOC: begin
        // LIFO reuse first, then a never-used slot, else full.
        if (free_depth > 0) begin
          free_depth--;
          id = free_ids[free_depth];
        end else if (fresh_mark < NUM_SLOTS) begin
          id = fresh_mark;
          fresh_mark++;
        end else begin
          id = NUM_SLOTS;
        end
        if (id < NUM_SLOTS) begin
          slot_count[id] = '0;
          slot_live[id]  = 1'b1;
          live_ids.insert(live_ids.size(), id);
          bump_changes();
          r.granted = SLOT_W'(id);
          n_grant++;
        end else begin
          r.status = ST_FULL;
          n_full++;
        end
      end
      CMD_ADD_REF: begin
        if (!in_range || !slot_live[slot]) begin
          r.status = ST_BAD;
          n_bad++;
        end else begin
          if (slot_count[slot] != '1)
            slot_count[slot] = slot_count[slot] + 1'b1;
          r.count = clip_count(slot_count[slot]);
        end
      end
      CMD_RELEASE: begin
        if (!in_range || !slot_live[slot] || slot_count[slot] == '0) begin
          r.status = ST_BAD;
          if (in_range)
            r.count = clip_count(slot_count[slot]);
          n_bad++;
        end else begin
          slot_count[slot] = slot_count[slot] - 1'b1;
          if (slot_count[slot] == '0) begin
            r.freed         = 1'b1;
            slot_live[slot] = 1'b0;
            hits = live_ids.find_first_index(x) with (x == slot);
            if (hits.size() != 0)
              live_ids.delete(hits[0]);
            if (free_depth < NUM_SLOTS) begin
              free_ids[free_depth] = slot;
              free_depth++;
            end
            bump_changes();
            n_free++;
          end
          r.count = clip_count(slot_count[slot]);
        end
      end
      CMD_MARK: begin
        if (!in_range) begin
          r.status = ST_BAD;
          n_bad++;
        end else begin
          bump_changes();
          r.count = clip_count(slot_count[slot]);
        end
      end
      CMD_CLEAR: pending = '0;
      default: ;  // reserved codes leave everything alone
    endcase
    r.changes = pending;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot();
    return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
  endfunction

  // Mostly a live slot, so add-ref/release get past the dead-slot check.
  function automatic logic [SLOT_W-1:0] pick_live();
    if (live_ids.size() == 0)
      return rand_slot();
    return SLOT_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
  endfunction

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------
  // Holds the beat until the edge that takes it (start_i high, busy_o low
  // before the edge), then records the prediction. start_i is left high so
  // a back-to-back beat never sees two assignments in one step.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    start_i   <= 1'b1;
    command_i <= cmd;
    slot_id_i <= slot;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.insert(expected_q.size(), apply_command(cmd, slot));
    n_sent++;
  endtask

  // Bursty pacing: random burst lengths, random gaps with junk on the
  // payload while start_i is low.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        start_i   <= 1'b0;
        command_i <= CMD_W'($urandom);
        slot_id_i <= rand_slot();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_beat(cmd, slot);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: done_o is a one-cycle strobe, sampled at the edge that
  // ends its cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    slot_result_t got, want;
    if (rst_ni && done_o) begin
      got = '{granted: granted_id_o, status: status_o, freed: freed_o,
              count: ref_count_o, changes: change_count_o};
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] unexpected beat: g=%0d s=%0d f=%0d c=%0d p=%0d",
                   $realtime, got.granted, got.status, got.freed, got.count,
                   got.changes);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $write("[%0t] beat %0d mismatch: exp g=%0d s=%0d f=%0d c=%0d p=%0d",
                   $realtime, n_checked, want.granted, want.status, want.freed,
                   want.count, want.changes);
            $display(" | got g=%0d s=%0d f=%0d c=%0d p=%0d",
                     got.granted, got.status, got.freed, got.count, got.changes);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles with no beat in either direction.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
        $display("refcounted_slot_allocator_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Fresh block: nothing live, pending counter at zero.
  task automatic test_idle_block();
    issue(CMD_CLEAR, rand_slot());
    issue(CMD_MARK, '1);                // dead slot still counts as a change
    issue(CMD_ADD_REF, '0);             // add-ref on a dead slot
    issue(CMD_RELEASE, '1);             // release of a dead slot
    issue(CMD_RSVD_LAST, '1);           // ignored codes
    issue(CMD_RSVD_FIRST, '0);
  endtask

  // One slot through its whole life, plus stack reuse.
  task automatic test_slot_lifecycle();
    issue(CMD_ALLOC, rand_slot());      // slot 0
    issue(CMD_ALLOC, rand_slot());      // slot 1
    issue(CMD_ADD_REF, 10'd0);
    issue(CMD_ADD_REF, 10'd0);
    issue(CMD_RELEASE, 10'd1);          // live but count zero
    issue(CMD_RELEASE, 10'd0);
    issue(CMD_RELEASE, 10'd0);          // drops to zero, slot freed
    issue(CMD_RELEASE, 10'd0);          // now dead
    issue(CMD_ALLOC, rand_slot());      // reuses slot 0 from the stack
    issue(CMD_ADD_REF, 10'd1);
    issue(CMD_RELEASE, 10'd1);          // freed
    issue(CMD_ALLOC, rand_slot());      // reuses slot 1
    issue(CMD_MARK, 10'd0);
    issue(CMD_CLEAR, rand_slot());
  endtask

  // Random mix, biased toward live slots so counts move up and down and
  // freed slots come back through the stack.
  task automatic test_random_traffic();
    int sel;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20)
        issue(CMD_ALLOC, rand_slot());
      else if (sel < 50)
        issue(CMD_ADD_REF, pick_live());
      else if (sel < 80)
        issue(CMD_RELEASE, pick_live());
      else if (sel < 88)
        issue(CMD_MARK, rand_slot());
      else if (sel < 92)
        issue(CMD_CLEAR, rand_slot());
      else if (sel < 96)
        issue(CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), rand_slot());
      else
        issue(($urandom_range(0, 1) != 0) ? CMD_ADD_REF : CMD_RELEASE, rand_slot());
    end
  endtask

  // Run one slot's count up with back-to-back beats, then step it down and up.
  task automatic test_count_climb();
    logic [SLOT_W-1:0] s;
    issue(CMD_ALLOC, rand_slot());
    s = expected_q[$].granted;
    for (int i = 0; i < RUN_BEATS; i++)
      send_beat(CMD_ADD_REF, s);
    send_beat(CMD_RELEASE, s);
    send_beat(CMD_ADD_REF, s);
  endtask

  // Pending-change counter climbs on back-to-back marks, then clears.
  task automatic test_pending_climb();
    issue(CMD_CLEAR, rand_slot());
    for (int i = 0; i < RUN_BEATS; i++)
      send_beat(CMD_MARK, rand_slot());
    issue(CMD_ALLOC, rand_slot());
    issue(CMD_CLEAR, rand_slot());
  endtask

  // Free three slots in order and check they come back last-in first-out.
  task automatic test_lifo_reuse();
    logic [SLOT_W-1:0] ids [3];
    for (int k = 0; k < 3; k++) begin
      issue(CMD_ALLOC, rand_slot());
      ids[k] = expected_q[$].granted;
    end
    for (int k = 0; k < 3; k++) begin
      issue(CMD_ADD_REF, ids[k]);
      issue(CMD_RELEASE, ids[k]);
    end
    repeat (3) issue(CMD_ALLOC, rand_slot());
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    n_sent     = 0;
    n_checked  = 0;
    n_mismatch = 0;
    n_grant    = 0;
    n_free     = 0;
    n_full     = 0;
    n_bad      = 0;
    burst_left = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_block();
    test_slot_lifecycle();
    test_random_traffic();
    test_count_climb();
    test_pending_climb();
    test_lifo_reuse();

    // Drain; the watchdog bounds this wait.
    @(posedge clk_i);
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      n_mismatch++;
      $display("%0d predicted results never arrived", expected_q.size());
    end

    $display("covered %0d commands: %0d grants, %0d frees, %0d full, %0d bad slot/count",
             n_sent, n_grant, n_free, n_full, n_bad);
    $display("%0d result beats checked, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0)
      $display("refcounted_slot_allocator_tb: PASS");
    else
      $display("refcounted_slot_allocator_tb: FAIL");
    $finish;
  end

endmodule
